// ===== rtl/dcm_pkg.sv =====
// Shared constants and types for the dimmer channel level mixer.
// No dependencies.
`default_nettype none

package dcm_pkg;

  localparam int CHANNELS      = 8;
  localparam int UNIVERSE_SIZE = 512;
  localparam int LANES         = 8;

  localparam int ADDR_W = 9;
  localparam int LVL_W  = 8;
  localparam int WORD_W = LANES * LVL_W;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LVL_W-1:0]  level_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0]        phase_t;
  typedef logic [2:0]        chase_t;

  localparam phase_t PH_UP   = 2'd0;
  localparam phase_t PH_DOWN = 2'd1;
  localparam phase_t PH_NEXT = 2'd2;

  localparam addr_t  ADDR_CHASE = 9'd256;
  localparam level_t LVL_FULL   = 8'd255;
  localparam level_t LVL_TOP_DN = 8'd254;

  typedef struct packed {
    addr_t addr;
    word_t local_lv;
    word_t dmx_lv;
    logic  dmx_ok;
  } beat_t;

endpackage

`default_nettype wire

// ===== rtl/dcm_core.sv =====
// Level merge, test patterns and fade generator with the held channel state.
// Depends on dcm_pkg.
`default_nettype none

module dcm_core
  import dcm_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        fire,
  input  wire        test_mode,
  input  wire beat_t beat,
  output word_t      levels_nxt
);

  level_t held_r   [LANES];
  level_t held_nxt [LANES];
  level_t fade_r, fade_nxt;
  phase_t phase_r, phase_nxt;
  chase_t chase_r, chase_nxt;

  phase_t ph_mid;
  chase_t chase_inc;
  logic   is_chase;
  logic   is_fade;
  logic   is_zero;

  assign is_chase  = (beat.addr == ADDR_CHASE);
  assign is_fade   = beat.addr[ADDR_W-1];
  assign is_zero   = (beat.addr == '0);
  assign chase_inc = chase_r + 3'd1;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      level_t l;
      level_t d;
      l = beat.local_lv[k*LVL_W +: LVL_W];
      d = beat.dmx_lv[k*LVL_W +: LVL_W];
      held_nxt[k] = held_r[k];
      if (k < CHANNELS) begin
        if (test_mode) begin
          if (is_chase) begin
            held_nxt[k] = (chase_r == 3'(k)) ? fade_r : '0;
          end else if (is_fade) begin
            held_nxt[k] = beat.addr[k] ? fade_r : '0;
          end else if (is_zero) begin
            held_nxt[k] = l;
          end else begin
            held_nxt[k] = beat.addr[k] ? LVL_FULL : '0;
          end
        end else if (beat.dmx_ok) begin
          if (({1'b0, beat.addr} + 10'(k)) < 10'(UNIVERSE_SIZE)) begin
            held_nxt[k] = (d > l) ? d : l;
          end
        end else begin
          held_nxt[k] = l;
        end
      end else begin
        held_nxt[k] = '0;
      end
      levels_nxt[k*LVL_W +: LVL_W] = held_nxt[k];
    end
  end

  always_comb begin
    chase_nxt = chase_r;
    ph_mid    = phase_r;
    if (test_mode && is_fade && phase_r == PH_NEXT) begin
      ph_mid = PH_UP;
      if (is_chase) begin
        chase_nxt = ({1'b0, chase_inc} >= 4'(CHANNELS)) ? 3'd0 : chase_inc;
      end
    end
    fade_nxt  = fade_r;
    phase_nxt = ph_mid;
    if (test_mode) begin
      unique case (ph_mid)
        PH_UP: begin
          if (fade_r == LVL_FULL) begin
            fade_nxt  = LVL_TOP_DN;
            phase_nxt = PH_DOWN;
          end else begin
            fade_nxt = fade_r + 8'd1;
          end
        end
        PH_DOWN: begin
          if (fade_r == '0) begin
            phase_nxt = PH_NEXT;
          end else begin
            fade_nxt = fade_r - 8'd1;
          end
        end
        PH_NEXT: begin
          fade_nxt = '0;
        end
        default: begin
          fade_nxt = fade_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANES; k++) begin
        held_r[k] <= '0;
      end
      fade_r  <= '0;
      phase_r <= PH_UP;
      chase_r <= '0;
    end else if (fire) begin
      for (int k = 0; k < LANES; k++) begin
        held_r[k] <= held_nxt[k];
      end
      fade_r  <= fade_nxt;
      phase_r <= phase_nxt;
      chase_r <= chase_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dimmer_channel_level_mixer_top.sv =====
// Top level of the dimmer channel level mixer: input register, mixer core,
// result register. Depends on dcm_pkg and dcm_core.
`default_nettype none

// One beat per refresh tick goes in, one beat of eight packed channel levels
// comes out. A beat is taken every cycle while in_ready is high; the result
// passes through the input register, then the result register. A stalled
// result register holds the input register, which then holds in_ready low.
// The core state (held levels, fade level and phase, chase index) advances
// as a beat moves from the input register into the result register, so
// results come out strictly in input order. Write test_mode only while no
// beat is in flight.
module dimmer_channel_level_mixer_top
  import dcm_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire         cfg_wdata,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [8:0]  in_switch_address,
  input  wire  [63:0] in_local_levels,
  input  wire  [63:0] in_dmx_levels,
  input  wire         in_dmx_valid,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_channel_levels
);

  logic  test_mode_r;
  logic  s1_v_r;
  beat_t s1_r;
  logic  out_v_r;
  word_t out_r;
  word_t levels_nxt;
  logic  fire;

  assign fire     = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_mode_r <= 1'b0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        test_mode_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r.addr     <= in_switch_address;
      s1_r.local_lv <= in_local_levels;
      s1_r.dmx_lv   <= in_dmx_levels;
      s1_r.dmx_ok   <= in_dmx_valid;
    end
    if (fire) begin
      out_r <= levels_nxt;
    end
  end

  dcm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .test_mode  (test_mode_r),
    .beat       (s1_r),
    .levels_nxt (levels_nxt)
  );

  assign out_valid          = out_v_r;
  assign out_channel_levels = out_r;

endmodule

`default_nettype wire
